// ===== rtl/arx_plant_model_filter_top_macros.svh =====
// Assertion macros for the ARX plant model filter checker.
// Clocked on i_clk and disabled while i_rst_n is low; no other dependencies.
`ifndef ARX_PLANT_MODEL_FILTER_TOP_MACROS_SVH
`define ARX_PLANT_MODEL_FILTER_TOP_MACROS_SVH

// Same-cycle implication.
`define ARX_AST_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ARX_AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/arx_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the ARX plant model filter.
// No dependencies; used by every module of the block.
package arx_pkg;

    localparam int ORDER         = 4;
    localparam int MAX_DELAY     = 16;
    // The ring wraps by truncating the address, so the depth is a power of two.
    localparam int HISTORY_DEPTH = 32;

    localparam int SMP_W   = 24;
    localparam int COEF_W  = 16;
    localparam int NPACK   = 4;
    localparam int PROD_W  = SMP_W + COEF_W;
    localparam int ACC_W   = PROD_W + $clog2(2 * ORDER) + 1;
    localparam int FRAC    = 14;
    localparam int Y_W     = ACC_W - FRAC;
    localparam int RES_W   = Y_W + 1;
    localparam int HIST_AW = $clog2(HISTORY_DEPTH);
    localparam int K_W     = $clog2(2 * ORDER + 1);
    localparam int DLY_W   = $clog2(MAX_DELAY + 1);
    localparam int OIDX_W  = (ORDER > 1) ? $clog2(ORDER) : 1;
    localparam int NTAP_W  = $clog2(ORDER + 1);

    localparam int CFG_W   = 64;
    localparam int CFG_AW  = 6;

    localparam logic [2:0] REG_A_COEFFS    = 3'd0;
    localparam logic [2:0] REG_B_COEFFS    = 3'd1;
    localparam logic [2:0] REG_A_TAPS      = 3'd2;
    localparam logic [2:0] REG_B_TAPS      = 3'd3;
    localparam logic [2:0] REG_INPUT_DELAY = 3'd4;

    localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
    localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};

    typedef struct packed {
        logic vld;
        logic sub;
        logic clr;
    } t_mac_op;

    typedef struct packed {
        logic [SMP_W-1:0] v;
        logic             clip;
    } t_sat;

    // Pick coefficient i from a packed word; taps past the packed four are zero.
    function automatic logic signed [COEF_W-1:0] coef_sel(input logic [CFG_W-1:0] pk,
                                                          input logic [K_W-1:0]   i);
        logic signed [COEF_W-1:0] c;
        c = '0;
        case (i)
            K_W'(0): c = pk[15:0];
            K_W'(1): c = pk[31:16];
            K_W'(2): c = pk[47:32];
            K_W'(3): c = pk[63:48];
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic t_sat sat_smp(input logic signed [RES_W-1:0] x);
        t_sat s;
        if (x > $signed({{(RES_W-SMP_W){1'b0}}, SMP_MAX})) begin
            s.v    = SMP_MAX;
            s.clip = 1'b1;
        end else if (x < $signed({{(RES_W-SMP_W){1'b1}}, SMP_MIN})) begin
            s.v    = SMP_MIN;
            s.clip = 1'b1;
        end else begin
            s.v    = x[SMP_W-1:0];
            s.clip = 1'b0;
        end
        return s;
    endfunction

endpackage

// ===== rtl/arx_hist.sv =====
`timescale 1ns / 1ps
// Input history ring: one write port, one registered read port, per-entry valid bits.
// Depends on arx_pkg.
module arx_hist (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [arx_pkg::HIST_AW-1:0]   i_rd_addr,
    output logic [arx_pkg::SMP_W-1:0]     o_rd_data,
    input  logic                          i_wr_en,
    input  logic [arx_pkg::HIST_AW-1:0]   i_wr_addr,
    input  logic [arx_pkg::SMP_W-1:0]     i_wr_data
);

    logic [arx_pkg::SMP_W-1:0]         r_mem [arx_pkg::HISTORY_DEPTH];
    logic [arx_pkg::HISTORY_DEPTH-1:0] r_valid;
    logic [arx_pkg::SMP_W-1:0]         r_rdata;
    logic                              r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rvld  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rvld <= r_valid[i_rd_addr];
            end
        end
    end

    // Never-written entries read as zero.
    assign o_rd_data = r_rvld ? r_rdata : '0;

endmodule

// ===== rtl/arx_mac.sv =====
`timescale 1ns / 1ps
// Shared multiply-accumulate unit: registered product, then add or subtract into the sum.
// Depends on arx_pkg.
module arx_mac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  arx_pkg::t_mac_op                     i_op,
    input  logic signed [arx_pkg::COEF_W-1:0]    i_coef,
    input  logic signed [arx_pkg::SMP_W-1:0]     i_opnd,
    output logic signed [arx_pkg::ACC_W-1:0]     o_acc,
    output logic                                 o_busy
);

    logic signed [arx_pkg::PROD_W-1:0] r_prod;
    logic                              r_prod_vld;
    logic                              r_prod_sub;
    logic signed [arx_pkg::ACC_W-1:0]  r_acc;
    logic signed [arx_pkg::ACC_W-1:0]  w_prod_ext;

    always_ff @(posedge i_clk) begin
        r_prod     <= i_coef * i_opnd;
        r_prod_sub <= i_op.sub;
    end

    assign w_prod_ext = {{(arx_pkg::ACC_W-arx_pkg::PROD_W){r_prod[arx_pkg::PROD_W-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_prod_vld <= i_op.vld;
            if (i_op.clr) begin
                r_acc <= '0;
            end else if (r_prod_vld) begin
                r_acc <= r_prod_sub ? (r_acc - w_prod_ext) : (r_acc + w_prod_ext);
            end
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_prod_vld;

endmodule

// ===== rtl/arx_plant_model_filter_top.sv =====
`timescale 1ns / 1ps
// ARX plant model filter, top level: APB register file, tap sequencer, output stage.
// Depends on arx_pkg, arx_hist and arx_mac.
//
// Usage:
//   s_axis carries one item per plant step: u(t) and a noise sample, both Q11.12.
//   m_axis returns one item per input: rounded y(t) + noise, saturated to 24 bits,
//   with tuser set when that sum was clipped.
//   Registers are written over APB at byte address 8*i (a_coeffs, b_coeffs,
//   a_taps, b_taps, input_delay); write them only while the block is idle.
// Sequencing:
//   Taps run one per cycle through a single shared 16x24 multiplier and a 44-bit
//   accumulator, with n = min(a_taps,4) + min(b_taps,4) active taps. Each tap passes
//   the operand register, the product register and the accumulator; the sum is then
//   rounded into r_y and committed to the output register. A new item is taken only
//   once the block is back in idle after the commit.
// Reset:
//   Synchronous, active low. Clears input and output histories (history never
//   written reads as zero), the ring pointer and all configuration registers; input_delay = 1.
// Stalls:
//   The output register holds a result until m_axis_tready; meanwhile one more
//   item may be accepted and computed, and its commit waits for the slot.
module arx_plant_model_filter_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // APB configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [arx_pkg::CFG_AW-1:0]   paddr,
    input  logic [arx_pkg::CFG_W-1:0]    pwdata,
    output logic [arx_pkg::CFG_W-1:0]    prdata,
    output logic                         pready,
    // input items
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [47:0]                  s_axis_tdata,   // [23:0] in_sample, [47:24] noise_sample
    // result items
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [23:0]                  m_axis_tdata,   // [23:0] out_sample
    output logic                         m_axis_tuser    // [0] saturated
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ISSUE  = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_ROUND  = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;

    // configuration registers
    logic [arx_pkg::CFG_W-1:0] r_a_coeffs;
    logic [arx_pkg::CFG_W-1:0] r_b_coeffs;
    logic [2:0]                r_a_taps;
    logic [2:0]                r_b_taps;
    logic [4:0]                r_input_delay;

    // sequencer
    logic [2:0]                          r_state;
    logic [arx_pkg::K_W-1:0]             r_k;
    logic [arx_pkg::NTAP_W-1:0]          r_na;
    logic [arx_pkg::NTAP_W-1:0]          r_nb;
    logic [arx_pkg::DLY_W-1:0]           r_d;
    logic signed [arx_pkg::SMP_W-1:0]    r_u;
    logic signed [arx_pkg::SMP_W-1:0]    r_nz;
    logic [arx_pkg::HIST_AW-1:0]         r_wp;
    logic signed [arx_pkg::SMP_W-1:0]    r_yh [arx_pkg::ORDER];

    // tap operand stage
    logic                                r_s1_vld;
    logic                                r_s1_sub;
    logic signed [arx_pkg::COEF_W-1:0]   r_s1_coef;
    logic signed [arx_pkg::SMP_W-1:0]    r_s1_yh;

    // rounding and output
    logic signed [arx_pkg::Y_W-1:0]      r_y;
    logic [arx_pkg::SMP_W-1:0]           r_out;
    logic                                r_out_sat;
    logic                                r_out_vld;

    logic                                w_cfg_wr;
    logic                                w_in_acc;
    logic [arx_pkg::K_W-1:0]             w_ntot;
    logic                                w_is_b;
    logic [arx_pkg::K_W-1:0]             w_i;
    logic                                w_issue;
    logic [arx_pkg::HIST_AW-1:0]         w_rd_addr;
    logic [arx_pkg::SMP_W-1:0]           w_hist_data;
    logic                                w_commit;
    logic [arx_pkg::NTAP_W-1:0]          w_na_clamp;
    logic [arx_pkg::NTAP_W-1:0]          w_nb_clamp;
    logic [arx_pkg::DLY_W-1:0]           w_d_clamp;
    logic signed [arx_pkg::ACC_W-1:0]    w_acc;
    logic signed [arx_pkg::ACC_W-1:0]    w_rnd;
    logic                                w_mac_busy;
    logic signed [arx_pkg::RES_W-1:0]    w_y_ext;
    logic signed [arx_pkg::RES_W-1:0]    w_res;
    arx_pkg::t_sat                       w_ysat;
    arx_pkg::t_sat                       w_rsat;
    arx_pkg::t_mac_op                    w_mac_op;
    logic signed [arx_pkg::SMP_W-1:0]    w_opnd;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_coeffs    <= '0;
            r_b_coeffs    <= '0;
            r_a_taps      <= '0;
            r_b_taps      <= '0;
            r_input_delay <= 5'd1;
        end else if (w_cfg_wr) begin
            case (paddr[5:3])
                arx_pkg::REG_A_COEFFS:    r_a_coeffs    <= pwdata;
                arx_pkg::REG_B_COEFFS:    r_b_coeffs    <= pwdata;
                arx_pkg::REG_A_TAPS:      r_a_taps      <= pwdata[2:0];
                arx_pkg::REG_B_TAPS:      r_b_taps      <= pwdata[2:0];
                arx_pkg::REG_INPUT_DELAY: r_input_delay <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            arx_pkg::REG_A_COEFFS:    prdata = r_a_coeffs;
            arx_pkg::REG_B_COEFFS:    prdata = r_b_coeffs;
            arx_pkg::REG_A_TAPS:      prdata = {{(arx_pkg::CFG_W-3){1'b0}}, r_a_taps};
            arx_pkg::REG_B_TAPS:      prdata = {{(arx_pkg::CFG_W-3){1'b0}}, r_b_taps};
            arx_pkg::REG_INPUT_DELAY: prdata = {{(arx_pkg::CFG_W-5){1'b0}}, r_input_delay};
            default:                  prdata = '0;
        endcase
    end

    // Clamp tap counts to the order and the dead time to 1..MAX_DELAY.
    always_comb begin
        w_na_clamp = (32'(r_a_taps) > arx_pkg::ORDER) ? arx_pkg::NTAP_W'(arx_pkg::ORDER)
                                                       : arx_pkg::NTAP_W'(r_a_taps);
        w_nb_clamp = (32'(r_b_taps) > arx_pkg::ORDER) ? arx_pkg::NTAP_W'(arx_pkg::ORDER)
                                                       : arx_pkg::NTAP_W'(r_b_taps);
        if (r_input_delay == 5'd0) begin
            w_d_clamp = arx_pkg::DLY_W'(1);
        end else if (32'(r_input_delay) > arx_pkg::MAX_DELAY) begin
            w_d_clamp = arx_pkg::DLY_W'(arx_pkg::MAX_DELAY);
        end else begin
            w_d_clamp = arx_pkg::DLY_W'(r_input_delay);
        end
    end

    // ---------------- tap sequencer ----------------
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // b taps first (k < nb), then a taps.
    assign w_ntot    = arx_pkg::K_W'(r_na) + arx_pkg::K_W'(r_nb);
    assign w_is_b    = (r_k < arx_pkg::K_W'(r_nb));
    assign w_i       = w_is_b ? r_k : (r_k - arx_pkg::K_W'(r_nb));
    assign w_issue   = (r_state == ST_ISSUE) && (r_k < w_ntot);
    // u(t-d-i) sits d+i slots behind the write pointer
    assign w_rd_addr = r_wp - arx_pkg::HIST_AW'(r_d) - arx_pkg::HIST_AW'(w_i);
    assign w_commit  = (r_state == ST_COMMIT) && (!r_out_vld || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_k      <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_issue;
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_k     <= '0;
                        r_state <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    if (w_issue) begin
                        r_k <= r_k + arx_pkg::K_W'(1);
                    end else begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!r_s1_vld && !w_mac_busy) begin
                        r_state <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    r_state <= ST_COMMIT;
                end
                ST_COMMIT: begin
                    if (w_commit) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Latch the item and the clamped settings for the whole step.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_u  <= s_axis_tdata[23:0];
            r_nz <= s_axis_tdata[47:24];
            r_na <= w_na_clamp;
            r_nb <= w_nb_clamp;
            r_d  <= w_d_clamp;
        end
        if (w_issue) begin
            r_s1_sub  <= !w_is_b;
            r_s1_coef <= w_is_b ? arx_pkg::coef_sel(r_b_coeffs, w_i)
                                : arx_pkg::coef_sel(r_a_coeffs, w_i);
            r_s1_yh   <= r_yh[w_i[arx_pkg::OIDX_W-1:0]];
        end
        if (r_state == ST_ROUND) begin
            r_y <= w_rnd[arx_pkg::ACC_W-1:arx_pkg::FRAC];
        end
    end

    arx_hist u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_issue),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_hist_data),
        .i_wr_en   (w_commit),
        .i_wr_addr (r_wp),
        .i_wr_data (r_u)
    );

    // a taps subtract, operand from the output history; b taps add, from the ring
    assign w_mac_op.vld = r_s1_vld;
    assign w_mac_op.sub = r_s1_sub;
    assign w_mac_op.clr = w_in_acc;
    assign w_opnd       = r_s1_sub ? r_s1_yh : w_hist_data;

    arx_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_mac_op),
        .i_coef  (r_s1_coef),
        .i_opnd  (w_opnd),
        .o_acc   (w_acc),
        .o_busy  (w_mac_busy)
    );

    // ---------------- rounding, history update, output ----------------
    // round half up: add half an LSB, then floor shift by FRAC
    assign w_rnd   = w_acc + arx_pkg::ACC_W'(1 << (arx_pkg::FRAC - 1));
    assign w_y_ext = {r_y[arx_pkg::Y_W-1], r_y};
    assign w_res   = w_y_ext + {{(arx_pkg::RES_W-arx_pkg::SMP_W){r_nz[arx_pkg::SMP_W-1]}}, r_nz};
    assign w_ysat  = arx_pkg::sat_smp(w_y_ext);
    assign w_rsat  = arx_pkg::sat_smp(w_res);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_out_vld <= 1'b0;
            for (int j = 0; j < arx_pkg::ORDER; j++) begin
                r_yh[j] <= '0;
            end
        end else begin
            if (w_commit) begin
                // shift the noise-free, saturated y into the output history
                for (int j = arx_pkg::ORDER - 1; j > 0; j--) begin
                    r_yh[j] <= r_yh[j-1];
                end
                r_yh[0]   <= w_ysat.v;
                r_wp      <= r_wp + arx_pkg::HIST_AW'(1);
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out     <= w_rsat.v;
            r_out_sat <= w_rsat.clip;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;
    assign m_axis_tuser  = r_out_sat;

endmodule

// ===== rtl/arx_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker for the ARX plant model filter, bound to the top level.
// Depends on arx_pkg and arx_plant_model_filter_top_macros.svh.
`include "arx_plant_model_filter_top_macros.svh"

module arx_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         pready,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [23:0]                  m_axis_tdata,
    input logic                         m_axis_tuser
);

    // hold a pending result until it is taken
    `ARX_AST_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // the block goes busy right after it takes an item
    `ARX_AST_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // a clipped result sits on one of the two rails
    `ARX_AST_IMPL(a_sat_rail, m_axis_tvalid && m_axis_tuser, (m_axis_tdata == arx_pkg::SMP_MAX) || (m_axis_tdata == arx_pkg::SMP_MIN))

    // configuration writes never wait
    `ARX_AST_IMPL(a_pready_high, 1'b1, pready)

endmodule

bind arx_plant_model_filter_top arx_chk u_arx_chk (.*);

// ===== verif/arx_plant_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the ARX plant model filter: tracks APB register writes, predicts each
// result item from the accepted input items and compares it with the block's output.
// Depends on arx_pkg for widths, register codes and saturation limits.
module arx_plant_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic                       i_pready,
    input  logic [arx_pkg::CFG_AW-1:0] i_paddr,
    input  logic [arx_pkg::CFG_W-1:0]  i_pwdata,
    input  logic                       i_s_tvalid,
    input  logic                       i_s_tready,
    input  logic [47:0]                i_s_tdata,   // [23:0] in_sample, [47:24] noise_sample
    input  logic                       i_m_tvalid,
    input  logic                       i_m_tready,
    input  logic [23:0]                i_m_tdata,   // [23:0] out_sample
    input  logic                       i_m_tuser,   // [0] saturated
    output int                         o_mismatch_count,
    output int                         o_pending
);

    typedef struct packed {
        logic signed [23:0] out_sample;
        logic               saturated;
    } t_plant_out;

    t_plant_out expected_outputs[$];

    logic [63:0] a_coef_reg;
    logic [63:0] b_coef_reg;
    logic [2:0]  a_taps_reg;
    logic [2:0]  b_taps_reg;
    logic [4:0]  delay_reg;

    logic signed [23:0]               u_ring [0:arx_pkg::HISTORY_DEPTH-1];
    logic signed [23:0]               y_hist [0:arx_pkg::ORDER-1];
    logic [arx_pkg::HIST_AW-1:0]      wr_ptr;
    int                               mismatches = 0;

    function automatic t_plant_out clip24(input longint x);
        t_plant_out r;
        r.saturated = 1'b0;
        if (x > longint'(arx_pkg::SMP_MAX)) begin
            r.out_sample = arx_pkg::SMP_MAX;
            r.saturated  = 1'b1;
        end else if (x < longint'(arx_pkg::SMP_MIN)) begin
            r.out_sample = arx_pkg::SMP_MIN;
            r.saturated  = 1'b1;
        end else begin
            r.out_sample = x[23:0];
        end
        return r;
    endfunction

    // One plant step: exact sum of products, round half up, store clipped y, queue y + noise.
    task automatic step_plant(input logic signed [23:0] u, input logic signed [23:0] nz);
        longint                      acc;
        longint                      y;
        t_plant_out                  stored;
        int                          na;
        int                          nb;
        int                          d;
        int                          i;
        logic [arx_pkg::HIST_AW-1:0] idx;
        na = (a_taps_reg > arx_pkg::ORDER) ? arx_pkg::ORDER : int'(a_taps_reg);
        nb = (b_taps_reg > arx_pkg::ORDER) ? arx_pkg::ORDER : int'(b_taps_reg);
        d  = delay_reg;
        if (d < 1) d = 1;
        if (d > arx_pkg::MAX_DELAY) d = arx_pkg::MAX_DELAY;
        acc = 0;
        for (i = 0; i < nb; i++) begin
            idx = wr_ptr - arx_pkg::HIST_AW'(d + i);
            acc += longint'($signed(b_coef_reg[16*i +: 16])) * longint'(u_ring[idx]);
        end
        for (i = 0; i < na; i++) begin
            acc -= longint'($signed(a_coef_reg[16*i +: 16])) * longint'(y_hist[i]);
        end
        y = (acc + 64'sd8192) >>> 14;
        stored = clip24(y);
        expected_outputs.push_back(clip24(y + longint'(nz)));
        for (i = arx_pkg::ORDER - 1; i > 0; i--) y_hist[i] = y_hist[i-1];
        y_hist[0] = stored.out_sample;
        u_ring[wr_ptr] = u;
        wr_ptr = wr_ptr + 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_plant_out got;
        t_plant_out want;
        if (!i_rst_n) begin
            a_coef_reg = '0;
            b_coef_reg = '0;
            a_taps_reg = '0;
            b_taps_reg = '0;
            delay_reg  = 5'd1;
            for (int k = 0; k < arx_pkg::HISTORY_DEPTH; k++) u_ring[k] = '0;
            for (int k = 0; k < arx_pkg::ORDER; k++) y_hist[k] = '0;
            wr_ptr = '0;
            expected_outputs.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr[2:0] == 3'b000) begin
                case (i_paddr[5:3])
                    arx_pkg::REG_A_COEFFS:    a_coef_reg = i_pwdata;
                    arx_pkg::REG_B_COEFFS:    b_coef_reg = i_pwdata;
                    arx_pkg::REG_A_TAPS:      a_taps_reg = i_pwdata[2:0];
                    arx_pkg::REG_B_TAPS:      b_taps_reg = i_pwdata[2:0];
                    arx_pkg::REG_INPUT_DELAY: delay_reg  = i_pwdata[4:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got.out_sample = i_m_tdata;
                got.saturated  = i_m_tuser;
                if (expected_outputs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result out_sample=%0d saturated=%0b",
                                 $realtime, got.out_sample, got.saturated);
                end else begin
                    want = expected_outputs.pop_front();
                    if (got.out_sample !== want.out_sample || got.saturated !== want.saturated) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch out_sample exp %0d got %0d, saturated exp %0b got %0b",
                                     $realtime, want.out_sample, got.out_sample,
                                     want.saturated, got.saturated);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                step_plant(i_s_tdata[23:0], i_s_tdata[47:24]);
        end
        o_mismatch_count = mismatches;
        o_pending        = expected_outputs.size();
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Top of the ARX plant model filter testbench: clock, reset, APB and stream stimulus, verdict.
// Depends on arx_pkg, arx_plant_model_filter_top and arx_plant_checker.
module tb;

    // Cycles without any handshake or register write before the run is declared hung.
    localparam int QUIET_LIMIT = 3000;
    // Length of the long receiver hold-off that backs the block up into its input.
    localparam int HOLD_CYCLES = 300;
    localparam int ITEMS_PER_BLOCK = 71;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [arx_pkg::CFG_AW-1:0] paddr = '0;
    logic [arx_pkg::CFG_W-1:0]  pwdata = '0;
    logic [arx_pkg::CFG_W-1:0]  prdata;
    logic                       pready;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [47:0]                s_axis_tdata = '0;   // [23:0] in_sample, [47:24] noise_sample
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [23:0]                m_axis_tdata;        // [23:0] out_sample
    logic                       m_axis_tuser;        // [0] saturated

    int mismatch_count;
    int pending;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_req = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;

    arx_plant_model_filter_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    arx_plant_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_pready         (pready),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .i_s_tvalid       (s_axis_tvalid),
        .i_s_tready       (s_axis_tready),
        .i_s_tdata        (s_axis_tdata),
        .i_m_tvalid       (m_axis_tvalid),
        .i_m_tready       (m_axis_tready),
        .i_m_tdata        (m_axis_tdata),
        .i_m_tuser        (m_axis_tuser),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Receiver: drop tready at random, or hold it low for a long stretch once asked.
    always @(negedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_axis_tready = 1'b0;
            hold_left--;
        end else begin
            m_axis_tready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: any handshake or register write restarts the count.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // APB write with a setup phase and an access phase; starts and ends at a falling edge.
    task automatic apb_write(input logic [2:0] reg_idx, input logic [63:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_idx, 3'b000};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic load_config(input logic [63:0] a_pk, input logic [63:0] b_pk,
                               input logic [2:0] na, input logic [2:0] nb,
                               input logic [4:0] dly);
        apb_write(arx_pkg::REG_A_COEFFS, a_pk);
        apb_write(arx_pkg::REG_B_COEFFS, b_pk);
        apb_write(arx_pkg::REG_A_TAPS, {61'd0, na});
        apb_write(arx_pkg::REG_B_TAPS, {61'd0, nb});
        apb_write(arx_pkg::REG_INPUT_DELAY, {59'd0, dly});
    endtask

    // Offer one item after a random gap; hold tvalid high across back-to-back items.
    task automatic send_item(input logic [23:0] u, input logic [23:0] nz);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {nz, u};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Hold off the sender until every result is back, then let the pipeline settle.
    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // Four packed coefficients of magnitude up to mag, or fully random bits.
    function automatic logic [63:0] rand_coefs(input int mag);
        logic [63:0] w;
        int          i;
        for (i = 0; i < 4; i++) begin
            if (mag >= 32768) w[16*i +: 16] = 16'($urandom());
            else              w[16*i +: 16] = 16'($urandom_range(0, 2 * mag) - mag);
        end
        return w;
    endfunction

    // Mix of full-range, small and extreme values; full_pct sets the full-range share.
    function automatic logic [23:0] rand_sample(input int full_pct);
        int r;
        int k;
        r = $urandom_range(99);
        if (r < full_pct) return 24'($urandom());
        if (r < 88) return 24'($urandom_range(0, 131072) - 65536);
        k = $urandom_range(3);
        case (k)
            0:       return arx_pkg::SMP_MAX;
            1:       return arx_pkg::SMP_MIN;
            2:       return 24'd0;
            default: return 24'hFFFFFF;
        endcase
    endfunction

    initial begin
        logic [2:0] na;
        logic [2:0] nb;
        logic [4:0] dly;
        int         a_mag;
        int         b_mag;

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (4) @(negedge i_clk);

        tx_idle_pct = 31;
        rx_idle_pct = 80;

        // Reset defaults: no taps, so the output is the noise alone.
        send_item(arx_pkg::SMP_MAX, arx_pkg::SMP_MAX);
        send_item(arx_pkg::SMP_MIN, arx_pkg::SMP_MIN);
        send_item(24'hFFFFFF, 24'd1);
        send_item(24'd0, 24'd0);
        wait_drained();

        // Gain near two with unit feedback: stored y clips while y plus negative noise fits,
        // then the feedback exposes the clipped stored value.
        load_config(64'h0000_0000_0000_4000, 64'h0000_0000_0000_7FFF, 3'd1, 3'd1, 5'd1);
        send_item(arx_pkg::SMP_MAX, 24'd0);
        send_item(24'd0, arx_pkg::SMP_MIN);
        send_item(24'd0, 24'd0);
        send_item(arx_pkg::SMP_MIN, arx_pkg::SMP_MAX);
        send_item(24'd0, 24'd0);
        send_item(24'd0, 24'd0);
        wait_drained();

        // Extreme coefficients, tap counts above the order, zero delay.
        load_config({4{16'h8000}}, {4{16'h7FFF}}, 3'd7, 3'd5, 5'd0);
        send_item(arx_pkg::SMP_MAX, arx_pkg::SMP_MAX);
        send_item(arx_pkg::SMP_MIN, arx_pkg::SMP_MIN);
        send_item(arx_pkg::SMP_MAX, arx_pkg::SMP_MIN);
        send_item(arx_pkg::SMP_MIN, arx_pkg::SMP_MAX);
        send_item(24'd0, 24'd0);
        wait_drained();

        // Delay past the maximum reaches ring slots that were never written.
        load_config(rand_coefs(32768), {4{16'h8000}}, 3'd0, 3'd4, 5'd31);
        send_item(arx_pkg::SMP_MAX, 24'd0);
        send_item(arx_pkg::SMP_MIN, 24'd0);
        send_item(24'd1, 24'hFFFFFF);
        send_item(24'hFFFFFF, 24'd1);
        send_item(arx_pkg::SMP_MAX, arx_pkg::SMP_MAX);
        wait_drained();

        // Random part: three idle profiles, four register settings in each.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin tx_idle_pct = 31; rx_idle_pct = 80; end
                1:       begin tx_idle_pct = 80; rx_idle_pct = 31; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            for (int blk = 0; blk < 4; blk++) begin
                wait_drained();
                // Mostly stable settings with in-range taps; the last block of each
                // profile uses full-range coefficients and any register value.
                if (blk == 3) begin
                    a_mag = 32768;
                    b_mag = 32768;
                    na    = 3'($urandom_range(7));
                    nb    = 3'($urandom_range(7));
                    dly   = 5'($urandom_range(31));
                end else begin
                    a_mag = $urandom_range(1, 3500);
                    b_mag = $urandom_range(1, 12000);
                    na    = 3'($urandom_range(4));
                    nb    = 3'($urandom_range(1, 4));
                    dly   = (blk == 0) ? 5'(1 + 15 * phase / 2) : 5'($urandom_range(1, 16));
                end
                load_config(rand_coefs(a_mag), rand_coefs(b_mag), na, nb, dly);
                for (int n = 0; n < ITEMS_PER_BLOCK; n++) begin
                    // Back the block up once while the sender keeps offering items.
                    if (phase == 0 && blk == 1 && n == 10) hold_req = 1'b1;
                    send_item(rand_sample(50), rand_sample(15));
                end
            end
        end

        wait_drained();
        repeat (40) @(negedge i_clk);
        if (mismatch_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
